// ----- src/satlb_pkg.sv -----
`default_nettype none
package satlb_pkg;

   localparam int unsigned DEF_SETS = 16;
   localparam int unsigned DEF_WAYS = 4;

   localparam int unsigned OP_W    = 2;
   localparam int unsigned VPN_W   = 36;
   localparam int unsigned PPN_W   = 40;
   localparam int unsigned STAMP_W = 48;
   localparam int unsigned CNT_W   = 32;

   // The set index is the sum of per-nibble residues of the vpn, then reduced below SETS.
   // Nine nibble residues sum to less than 256 * SETS, so eight compare-and-subtract
   // steps finish the reduction, two per cycle after the summing cycle.
   localparam int unsigned MOD_CHUNK_W   = 4;
   localparam int unsigned MOD_CHUNKS    = VPN_W / MOD_CHUNK_W;
   localparam int unsigned MOD_RED_STEPS = 8;
   localparam int unsigned MOD_RED_PER   = 2;
   localparam int unsigned MOD_STEPS     = 1 + MOD_RED_STEPS / MOD_RED_PER;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef struct packed {
      logic req_ready;
      logic capture;
      logic mod_step;
      logic walk_start;
      logic rd_issue;
      logic way_next;
      logic best_update;
      logic hit_set;
      logic ins_write;
      logic sweep_step;
      logic finish_load;
   } cmd_type;

   typedef struct packed {
      logic   req_valid;
      logic   sweep_done;
      logic   mod_done;
      op_type op;
      logic   is_match;
      logic   is_invalid;
      logic   last_way;
      logic   rsp_free;
   } status_type;

endpackage
`default_nettype wire

// ----- src/satlb_req_if.sv -----
`default_nettype none
interface satlb_req_if;
   import satlb_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [VPN_W-1:0]   vpn;
   logic [PPN_W-1:0]   new_ppn;
   logic [STAMP_W-1:0] access_time;

   modport source (output valid, output operation, output vpn, output new_ppn,
                   output access_time, input ready);
   modport sink (input valid, input operation, input vpn, input new_ppn,
                 input access_time, output ready);
endinterface
`default_nettype wire

// ----- src/satlb_rsp_if.sv -----
`default_nettype none
interface satlb_rsp_if;
   import satlb_pkg::*;

   logic             valid;
   logic             ready;
   logic             hit;
   logic [PPN_W-1:0] ppn_out;
   logic [CNT_W-1:0] access_count;
   logic [CNT_W-1:0] hit_count;
   logic [CNT_W-1:0] miss_count;

   modport source (output valid, output hit, output ppn_out, output access_count,
                   output hit_count, output miss_count, input ready);
   modport sink (input valid, input hit, input ppn_out, input access_count,
                 input hit_count, input miss_count, output ready);
endinterface
`default_nettype wire

// ----- src/satlb_ctrl.sv -----
`default_nettype none
module satlb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  satlb_pkg::status_type  status,
   output satlb_pkg::cmd_type     cmd
);
   import satlb_pkg::*;

   typedef enum logic [5:0] {
      ST_SWEEP  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_MOD    = 6'b000100,
      ST_READ   = 6'b001000,
      ST_CHECK  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MOD;
            end
         end
         ST_MOD: begin
            if (!status.mod_done) begin
               cmd.mod_step = 1'b1;
            end else if (status.op == OP_LOOKUP || status.op == OP_INSERT) begin
               cmd.walk_start = 1'b1;
               state_in       = ST_READ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.op == OP_LOOKUP) begin
               if (status.is_match) begin
                  cmd.hit_set = 1'b1;
                  state_in    = ST_FINISH;
               end else if (status.last_way) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.way_next = 1'b1;
                  state_in     = ST_READ;
               end
            end else begin
               if (status.is_invalid || status.last_way) begin
                  cmd.ins_write = 1'b1;
                  state_in      = ST_FINISH;
               end else begin
                  cmd.best_update = 1'b1;
                  cmd.way_next    = 1'b1;
                  state_in        = ST_READ;
               end
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/satlb_dp.sv -----
`default_nettype none
module satlb_dp #(
   parameter int unsigned SETS = satlb_pkg::DEF_SETS,
   parameter int unsigned WAYS = satlb_pkg::DEF_WAYS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  satlb_pkg::cmd_type     cmd,
   output satlb_pkg::status_type  status,
   satlb_req_if.sink              req_ch,
   satlb_rsp_if.source            rsp_ch
);
   import satlb_pkg::*;

   localparam int unsigned SLOTS     = SETS * WAYS;
   localparam int unsigned SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned MCNT_W    = $clog2(MOD_STEPS + 1);
   localparam int unsigned ACC_W     = SET_W + MOD_RED_STEPS;
   localparam bit          SETS_POW2 = ((SETS & (SETS - 1)) == 0);
   localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = '1;

   // Entry storage, one word per slot; slot = set * WAYS + way.
   logic               mem_valid [SLOTS];
   logic [VPN_W-1:0]   mem_vpn   [SLOTS];
   logic [PPN_W-1:0]   mem_ppn   [SLOTS];
   logic [STAMP_W-1:0] mem_stamp [SLOTS];

   op_type             op_ff;
   logic [VPN_W-1:0]   vpn_ff;
   logic [PPN_W-1:0]   ppn_ff;
   logic [STAMP_W-1:0] time_ff;

   logic [ACC_W-1:0]   mod_acc_ff, mod_acc_in;
   logic [ACC_W-1:0]   mod_term [MOD_CHUNKS];
   logic [SET_W-1:0]   set_ff, set_in;
   logic [MCNT_W-1:0]  mod_cnt_ff;

   logic [WAY_W-1:0]   way_ff;
   logic [WAY_W-1:0]   best_way_ff;
   logic [STAMP_W-1:0] best_stamp_ff;

   logic               rd_valid_ff;
   logic [VPN_W-1:0]   rd_vpn_ff;
   logic [PPN_W-1:0]   rd_ppn_ff;
   logic [STAMP_W-1:0] rd_stamp_ff;

   logic               hit_ff;
   logic [PPN_W-1:0]   ppn_res_ff;

   logic [SLOT_W-1:0]  sweep_ff;

   logic [CNT_W-1:0]   lookups_ff, lookups_in;
   logic [CNT_W-1:0]   hits_ff, hits_in;
   logic [CNT_W-1:0]   misses_ff, misses_in;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [PPN_W-1:0]   rsp_ppn_ff;
   logic [CNT_W-1:0]   rsp_acc_ff;
   logic [CNT_W-1:0]   rsp_hits_ff;
   logic [CNT_W-1:0]   rsp_miss_ff;

   logic               take_cur;
   logic [WAY_W-1:0]   victim_way;
   logic [WAY_W-1:0]   wr_way;
   logic [SLOT_W-1:0]  rd_slot;
   logic [SLOT_W-1:0]  wr_slot;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

   // Residue of 2**e modulo SETS, evaluated at elaboration.
   function automatic int unsigned pow2_mod(input int unsigned e);
      int unsigned r;
      r = (SETS == 1) ? 0 : 1;
      for (int unsigned i = 0; i < e; i++) begin
         r = r * 2;
         if (r >= SETS) begin
            r = r - SETS;
         end
      end
      return r;
   endfunction

   // Each vpn nibble is weighted by the residue of its bit position.
   for (genvar g = 0; g < MOD_CHUNKS; g++) begin : g_mod_term
      localparam logic [ACC_W-1:0] RESIDUE = ACC_W'(pow2_mod(MOD_CHUNK_W * g));
      assign mod_term[g] = ACC_W'(vpn_ff[MOD_CHUNK_W*g +: MOD_CHUNK_W]) * RESIDUE;
   end

   // The first step sums the nibble terms; later steps subtract SETS times a falling
   // power of two, two at a time, which leaves the remainder.
   always_comb begin
      int k;
      mod_acc_in = mod_acc_ff;
      k          = 0;
      if (mod_cnt_ff == '0) begin
         mod_acc_in = '0;
         for (int g = 0; g < MOD_CHUNKS; g++) begin
            mod_acc_in = mod_acc_in + mod_term[g];
         end
      end else begin
         for (int r = 0; r < MOD_RED_PER; r++) begin
            k = int'(MOD_RED_STEPS) - int'(MOD_RED_PER) * int'(mod_cnt_ff)
                + int'(MOD_RED_PER) - 1 - r;
            if (k >= 0 && mod_acc_in >= (ACC_W'(SETS) << k)) begin
               mod_acc_in = mod_acc_in - (ACC_W'(SETS) << k);
            end
         end
      end
      set_in = mod_acc_in[SET_W-1:0];
   end

   // A way that is invalid, or the first way, or an older stamp becomes the candidate.
   always_comb begin
      take_cur   = !rd_valid_ff || (way_ff == '0) || (rd_stamp_ff < best_stamp_ff);
      victim_way = take_cur ? way_ff : best_way_ff;
      wr_way     = cmd.ins_write ? victim_way : way_ff;
      rd_slot    = SLOT_W'(32'(set_ff) * WAYS + 32'(way_ff));
      wr_slot    = SLOT_W'(32'(set_ff) * WAYS + 32'(wr_way));
   end

   always_comb begin
      lookups_in = lookups_ff;
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      case (op_ff)
         OP_LOOKUP: begin
            lookups_in = sat_inc(lookups_ff);
            if (hit_ff) begin
               hits_in = sat_inc(hits_ff);
            end else begin
               misses_in = sat_inc(misses_ff);
            end
         end
         OP_CLEAR: begin
            lookups_in = '0;
            hits_in    = '0;
            misses_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status.req_valid  = req_ch.valid;
      status.sweep_done = (sweep_ff == SLOT_W'(SLOTS - 1));
      status.mod_done   = SETS_POW2 || (mod_cnt_ff == MCNT_W'(MOD_STEPS));
      status.op         = op_ff;
      status.is_match   = rd_valid_ff && (rd_vpn_ff == vpn_ff);
      status.is_invalid = !rd_valid_ff;
      status.last_way   = (way_ff == WAY_W'(WAYS - 1));
      status.rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   end

   assign req_ch.ready        = cmd.req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.ppn_out      = rsp_ppn_ff;
   assign rsp_ch.access_count = rsp_acc_ff;
   assign rsp_ch.hit_count    = rsp_hits_ff;
   assign rsp_ch.miss_count   = rsp_miss_ff;

   always_ff @(posedge clock) begin
      if (cmd.sweep_step) begin
         mem_valid[sweep_ff] <= 1'b0;
      end else if (cmd.ins_write) begin
         mem_valid[wr_slot] <= 1'b1;
         mem_vpn[wr_slot]   <= vpn_ff;
         mem_ppn[wr_slot]   <= ppn_ff;
         mem_stamp[wr_slot] <= time_ff;
      end else if (cmd.hit_set) begin
         mem_stamp[wr_slot] <= time_ff;
      end
      if (cmd.rd_issue) begin
         rd_valid_ff <= mem_valid[rd_slot];
         rd_vpn_ff   <= mem_vpn[rd_slot];
         rd_ppn_ff   <= mem_ppn[rd_slot];
         rd_stamp_ff <= mem_stamp[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= op_type'(req_ch.operation);
         vpn_ff     <= req_ch.vpn;
         ppn_ff     <= req_ch.new_ppn;
         time_ff    <= req_ch.access_time;
         set_ff     <= SETS_POW2 ? (req_ch.vpn[SET_W-1:0] & SET_MASK) : '0;
         mod_cnt_ff <= '0;
         hit_ff     <= 1'b0;
         ppn_res_ff <= '0;
      end else if (cmd.mod_step) begin
         mod_acc_ff <= mod_acc_in;
         set_ff     <= set_in;
         mod_cnt_ff <= mod_cnt_ff + 1'b1;
      end
      if (cmd.walk_start) begin
         way_ff <= '0;
      end else if (cmd.way_next) begin
         way_ff <= way_ff + 1'b1;
      end
      if (cmd.best_update) begin
         best_way_ff <= victim_way;
         if (take_cur) begin
            best_stamp_ff <= rd_stamp_ff;
         end
      end
      if (cmd.hit_set) begin
         hit_ff     <= 1'b1;
         ppn_res_ff <= rd_ppn_ff;
      end
      if (cmd.finish_load) begin
         rsp_hit_ff  <= hit_ff;
         rsp_ppn_ff  <= ppn_res_ff;
         rsp_acc_ff  <= lookups_in;
         rsp_hits_ff <= hits_in;
         rsp_miss_ff <= misses_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         lookups_ff   <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.sweep_step && !status.sweep_done) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
         if (cmd.finish_load) begin
            lookups_ff   <= lookups_in;
            hits_ff      <= hits_in;
            misses_ff    <= misses_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

// ----- src/set_assoc_tlb_lru.sv -----
// Set-associative TLB with LRU replacement; one request is in work at a time.
// A lookup or insert reads and checks the ways of its set in order from way 0 until it is done
// (a lookup stops at the first hit, an insert at the first invalid way); other codes skip the scan.
// A set count that is not a power of two needs the vpn residue reduction; a power of two uses the low vpn bits.
// The response is registered once the previous one has been taken, and ready for the next request rises with it.
// After reset a sweep over all SETS*WAYS slots clears the valid bits before requests are taken.
`default_nettype none
module set_assoc_tlb_lru #(
   parameter int unsigned SETS = satlb_pkg::DEF_SETS,
   parameter int unsigned WAYS = satlb_pkg::DEF_WAYS
) (
   input  logic        clock,
   input  logic        reset,
   satlb_req_if.sink   req_ch,
   satlb_rsp_if.source rsp_ch
);
   import satlb_pkg::*;

   cmd_type    cmd;
   status_type status;

   satlb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   satlb_dp #(
      .SETS (SETS),
      .WAYS (WAYS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
`default_nettype wire
